// ===== hdl/irt_pkg.sv =====
// Shared types and codes for the interval reservation table.
// Used by the table cell and the top level.
package irt_pkg;

  // Request action codes
  localparam logic [1:0] ACT_SCHEDULE = 2'd0;
  localparam logic [1:0] ACT_CANCEL   = 2'd1;
  localparam logic [1:0] ACT_CHECK    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERLAP   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Latched request as broadcast to every cell
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] start_time;
    logic [16:0] finish;
  } req_t;

  // Update strobes broadcast to every cell
  typedef struct packed {
    logic        ins_en;
    logic        del_en;
    logic [15:0] move_begin;
    logic [16:0] move_finish;
  } cell_ctl_t;

  // Per-cell status seen by the top level
  typedef struct packed {
    logic valid;
    logic overlap;
    logic match;
    logic last;
  } cell_flags_t;

endpackage

// ===== hdl/irt_req_if.sv =====
// Request channel: valid/ready handshake with action, start and duration.
// Depends on nothing.
interface irt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] start_time;
  logic [15:0] duration;

  modport source (output valid, action, start_time, duration, input ready);
  modport sink   (input valid, action, start_time, duration, output ready);
endinterface

// ===== hdl/irt_res_if.sv =====
// Result channel: valid/ready handshake with status and entry count.
// Depends on nothing.
interface irt_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] entries_held;

  modport source (output valid, status, entries_held, input ready);
  modport sink   (input valid, status, entries_held, output ready);
endinterface

// ===== hdl/irt_cell.sv =====
// One slot of the reservation table: holds one interval, compares it with
// the broadcast request and updates from neighbor valid bits. Uses irt_pkg.
module irt_cell
  import irt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  cell_ctl_t   ctl,
  input  logic        prev_valid,
  input  logic        next_valid,
  output cell_flags_t flags,
  output logic [15:0] slot_begin,
  output logic [16:0] slot_finish
);

  logic valid;
  logic boundary;

  // Compares against the held interval
  always_comb begin
    flags.valid   = valid;
    flags.overlap = valid && ({1'b0, req.start_time} < slot_finish)
                          && (req.finish > {1'b0, slot_begin});
    flags.match   = valid && (slot_begin == req.start_time);
    flags.last    = valid && !next_valid;
  end

  // Occupied slots stay packed from cell 0; a new entry lands just above them
  assign boundary = !valid && prev_valid;

  // Valid bit: set on insert, cleared when this is the last slot on delete
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins_en && boundary) begin
      valid <= 1'b1;
    end else if (ctl.del_en && flags.last) begin
      valid <= 1'b0;
    end
  end

  // Payload: new request on insert, last slot's interval fills the hole
  always_ff @(posedge clk) begin
    if (ctl.ins_en && boundary) begin
      slot_begin  <= req.start_time;
      slot_finish <= req.finish;
    end else if (ctl.del_en && flags.match && !flags.last) begin
      slot_begin  <= ctl.move_begin;
      slot_finish <= ctl.move_finish;
    end
  end

endmodule

// ===== hdl/interval_reservation_table_core.sv =====
// Interval reservation table top level: request/result channels, a row of
// slot cells and the decision logic. Uses irt_pkg, irt_req_if, irt_res_if,
// irt_cell.
//
// Usage: send requests on req (action, start_time, duration); each one gives
// exactly one result on res (status, entries_held), in order.
// Schedule stores [start, start+duration) unless it overlaps a held interval
// (status overlap), the start is already held (status done, not stored) or
// the table is full (status full). Cancel frees the entry with that start or
// reports not found. Check reports overlap or free and changes nothing.
// Timing: a request is latched in the cycle it is taken, all cells compare
// in parallel in the next cycle and update, and the result register is
// loaded at that edge. No new request is taken while the latched one is
// being decided by the broadcast compare across all ENTRIES cells.
// While res is stalled the held result stays put and no new request is taken
// until it is taken or is being taken in the same cycle.
// Reset (synchronous, rst high) empties the table.
module interval_reservation_table_core
  import irt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst,
  irt_req_if.sink    req,
  irt_res_if.source  res
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic              busy;
  req_t              cur;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [1:0]        status_next;
  cell_ctl_t         ctl;
  cell_flags_t       flags [ENTRIES];
  logic [15:0]       begin_q [ENTRIES];
  logic [16:0]       finish_q [ENTRIES];
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] ovl_vec;
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] last_vec;
  logic              any_ovl;
  logic              any_match;
  logic              full;
  logic [CW+6:0]     held_wide;
  logic [15:0]       move_begin;
  logic [16:0]       move_finish;

  // Take a request only when idle and the result slot is free by next cycle
  assign req.ready = !busy && (!res.valid || res.ready);

  // Latch the request and form its 17-bit end
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cur.action     <= req.action;
      cur.start_time <= req.start_time;
      cur.finish     <= {1'b0, req.start_time} + {1'b0, req.duration};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= req.valid && req.ready;
    end
  end

  // Row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic pv;
    logic nv;
    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_mid
      assign pv = flags[i-1].valid;
    end
    if (i == ENTRIES - 1) begin : g_end
      assign nv = 1'b0;
    end else begin : g_inner
      assign nv = flags[i+1].valid;
    end

    irt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .req        (cur),
      .ctl        (ctl),
      .prev_valid (pv),
      .next_valid (nv),
      .flags      (flags[i]),
      .slot_begin (begin_q[i]),
      .slot_finish(finish_q[i])
    );

    assign valid_vec[i] = flags[i].valid;
    assign ovl_vec[i]   = flags[i].overlap;
    assign match_vec[i] = flags[i].match;
    assign last_vec[i]  = flags[i].last;
  end

  assign any_ovl   = |ovl_vec;
  assign any_match = |match_vec;
  assign full      = (count == CW'(ENTRIES));

  // Decision on the latched request
  always_comb begin
    ctl.ins_en      = 1'b0;
    ctl.del_en      = 1'b0;
    ctl.move_begin  = move_begin;
    ctl.move_finish = move_finish;
    status_next     = ST_DONE;
    count_next      = count;
    case (cur.action)
      ACT_SCHEDULE: begin
        if (any_ovl) begin
          status_next = ST_OVERLAP;
        end else if (any_match) begin
          status_next = ST_DONE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins_en = busy;
          count_next = count + CW'(1);
        end
      end
      ACT_CANCEL: begin
        if (any_match) begin
          ctl.del_en = busy;
          count_next = count - CW'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      ACT_CHECK: begin
        status_next = any_ovl ? ST_OVERLAP : ST_DONE;
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // Last occupied slot's interval, moved into a cancelled hole
  always_comb begin
    move_begin  = '0;
    move_finish = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      move_begin  = move_begin  | (begin_q[i]  & {16{last_vec[i]}});
      move_finish = move_finish | (finish_q[i] & {17{last_vec[i]}});
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (busy) begin
      count <= count_next;
    end
  end

  // Result register
  assign held_wide = {7'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (busy) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      res.status       <= status_next;
      res.entries_held <= held_wide[6:0];
    end
  end

  // Count tracks the occupied cells
  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count disagrees with occupied cells");

  // Starts are unique among held entries
  a_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one cell holds the same start");

  // Occupied cells stay packed: at most one last cell
  a_packed: assert property (@(posedge clk) disable iff (rst)
    $onehot0(last_vec))
    else $error("occupied cells are not contiguous");

  // A decision cycle always loads the result register
  a_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> res.valid)
    else $error("decided request produced no result");

endmodule
